// ----- rtl/core/bcpt_pkg.sv -----
// shared types, widths and constants for the battery charge percent tracker
package bcpt_pkg;

  localparam int CvW     = 16;  // pack voltage in 10 mV steps
  localparam int LoadW   = 8;
  localparam int CntW    = 4;
  localparam int CfgW    = 14;  // widest configuration register
  localparam int CfgIdxW = 3;
  localparam int VoltW   = 20;  // signed pack voltage in mV
  localparam int FloorW  = 18;  // count times per-battery floor
  localparam int SpanW   = 19;  // signed divisor before the positive check
  localparam int DsorW   = 18;  // positive divisor
  localparam int DiffW   = 19;  // excess over the floor
  localparam int NumW    = 25;  // 100 times the excess
  localparam int PctW    = 7;
  localparam int DivSteps = NumW;
  localparam int StepW   = $clog2(DivSteps);

  localparam logic [SpanW-1:0] FullScaleMv = SpanW'(14000);
  localparam logic [PctW-1:0]  PctMax      = PctW'(100);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNT   = 3'd0,
    CFG_KIND    = 3'd1,
    CFG_TUBULAR = 3'd2,
    CFG_FLAT    = 3'd3,
    CFG_EMPTY   = 3'd4,
    CFG_NOMINAL = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic commit;
    logic on_backup;
    logic fully_charged;
    logic restart;
  } trk_req_t;

endpackage

// ----- rtl/core/bcpt_if.sv -----
// request and result channel interfaces
interface bcpt_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [bcpt_pkg::CvW-1:0]    pack_centivolts;
  logic        [bcpt_pkg::LoadW-1:0]  load_pct;
  logic                               on_backup;
  logic                               fully_charged;
  logic                               restart_tracking;

  modport source (output valid, pack_centivolts, load_pct, on_backup, fully_charged,
                  restart_tracking, input ready);
  modport sink (input valid, pack_centivolts, load_pct, on_backup, fully_charged,
                restart_tracking, output ready);
endinterface

interface bcpt_out_if;
  logic                              valid;
  logic                              ready;
  logic [bcpt_pkg::PctW-1:0]         charge_pct_shown;
  logic [bcpt_pkg::PctW-1:0]         discharge_pct_shown;

  modport source (output valid, charge_pct_shown, discharge_pct_shown, input ready);
  modport sink (input valid, charge_pct_shown, discharge_pct_shown, output ready);
endinterface

// ----- rtl/core/bcpt_div.sv -----
// restoring divider, one quotient bit per cycle
module bcpt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bcpt_pkg::div_ctrl_t           ctrl,
  input  logic [bcpt_pkg::NumW-1:0]     dividend,
  input  logic [bcpt_pkg::DsorW-1:0]    divisor,
  output logic [bcpt_pkg::NumW-1:0]     quotient,
  output bcpt_pkg::div_stat_t           stat
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [bcpt_pkg::StepW-1:0]    step_r, step_nxt;
  logic [bcpt_pkg::NumW-1:0]     work_r, work_nxt;
  logic [bcpt_pkg::DsorW-1:0]    rem_r, rem_nxt;
  logic [bcpt_pkg::DsorW-1:0]    dsor_r, dsor_nxt;

  logic [bcpt_pkg::DsorW:0]      rem_sh;
  logic [bcpt_pkg::DsorW+1:0]    trial;
  logic                          fits;

  assign rem_sh = {rem_r, work_r[bcpt_pkg::NumW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dsor_r};
  assign fits   = ~trial[bcpt_pkg::DsorW+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = '0;
      work_nxt = dividend;
      rem_nxt  = '0;
      dsor_nxt = divisor;
    end else if (busy_r) begin
      work_nxt = {work_r[bcpt_pkg::NumW-2:0], fits};
      rem_nxt  = fits ? trial[bcpt_pkg::DsorW-1:0] : rem_sh[bcpt_pkg::DsorW-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == bcpt_pkg::StepW'(bcpt_pkg::DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
  end

  assign quotient  = work_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider busy and done together");

  a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |=> busy_r && !done_r && step_r == '0)
    else $error("divider start did not restart the count");

endmodule

// ----- rtl/core/bcpt_track.sv -----
// displayed percentages with their carry values and fresh flags
module bcpt_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bcpt_pkg::trk_req_t            req,
  input  logic [bcpt_pkg::NumW-1:0]     pct_raw,
  output logic [bcpt_pkg::PctW-1:0]     charge_shown,
  output logic [bcpt_pkg::PctW-1:0]     discharge_shown
);

  logic                        chg_fresh_r, chg_fresh_nxt;
  logic                        dis_fresh_r, dis_fresh_nxt;
  logic [bcpt_pkg::PctW-1:0]   chg_shown_r, chg_shown_nxt;
  logic [bcpt_pkg::PctW-1:0]   dis_shown_r, dis_shown_nxt;
  logic [bcpt_pkg::PctW-1:0]   carry_chg_r, carry_chg_nxt;
  logic [bcpt_pkg::PctW-1:0]   carry_dis_r, carry_dis_nxt;

  logic [bcpt_pkg::PctW-1:0]   pct_clamped;
  logic                        above_shown;
  logic                        below_carry;

  localparam int PadW = bcpt_pkg::NumW - bcpt_pkg::PctW;

  assign pct_clamped = (pct_raw > {{PadW{1'b0}}, bcpt_pkg::PctMax}) ?
                       bcpt_pkg::PctMax : pct_raw[bcpt_pkg::PctW-1:0];
  assign above_shown = pct_raw > {{PadW{1'b0}}, chg_shown_r};
  assign below_carry = pct_raw < {{PadW{1'b0}}, carry_dis_r};

  always_comb begin
    chg_fresh_nxt = chg_fresh_r;
    dis_fresh_nxt = dis_fresh_r;
    chg_shown_nxt = chg_shown_r;
    dis_shown_nxt = dis_shown_r;
    carry_chg_nxt = carry_chg_r;
    carry_dis_nxt = carry_dis_r;
    if (req.commit) begin
      if (!req.on_backup) begin
        dis_fresh_nxt = 1'b0;
        if (req.fully_charged) begin
          chg_shown_nxt = bcpt_pkg::PctMax;
        end else if (chg_fresh_r || req.restart || above_shown) begin
          chg_shown_nxt = pct_clamped;
          carry_dis_nxt = pct_clamped;
        end else begin
          chg_shown_nxt = carry_chg_r;
          carry_dis_nxt = carry_chg_r;
        end
      end else begin
        chg_fresh_nxt = 1'b0;
        if (dis_fresh_r || req.restart || below_carry) begin
          dis_shown_nxt = pct_clamped;
          carry_chg_nxt = pct_clamped;
        end else begin
          dis_shown_nxt = carry_dis_r;
          carry_chg_nxt = carry_dis_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_fresh_r <= 1'b1;
      dis_fresh_r <= 1'b1;
      chg_shown_r <= '0;
      dis_shown_r <= '0;
      carry_chg_r <= '0;
      carry_dis_r <= '0;
    end else begin
      chg_fresh_r <= chg_fresh_nxt;
      dis_fresh_r <= dis_fresh_nxt;
      chg_shown_r <= chg_shown_nxt;
      dis_shown_r <= dis_shown_nxt;
      carry_chg_r <= carry_chg_nxt;
      carry_dis_r <= carry_dis_nxt;
    end
  end

  assign charge_shown    = chg_shown_r;
  assign discharge_shown = dis_shown_r;

  a_shown_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    chg_shown_r <= bcpt_pkg::PctMax && dis_shown_r <= bcpt_pkg::PctMax)
    else $error("shown percentage above full scale");

  a_charged_forces_full: assert property (@(posedge clk) disable iff (!rst_n)
    req.commit && !req.on_backup && req.fully_charged |=> chg_shown_r == bcpt_pkg::PctMax)
    else $error("charged flag did not force full scale");

endmodule

// ----- rtl/core/battery_charge_percent_tracker_unit.sv -----
// battery charge percent tracker: sequencer, scaling datapath and config registers
//
// Requests come in on in_ch (valid/ready): one battery reading per request. Each
// accepted request gives exactly one result on out_ch carrying the displayed
// charging and discharging percentages after that reading. Registers are written
// through cfg_we/cfg_index/cfg_data, one per cycle; unknown indexes are ignored.
// Write them only while no request is in flight; the block does not enforce it.
// From acceptance a request goes through ST_PREP (floor and divisor),
// ST_SCALE (scaled excess), the bit-serial divide in ST_DIV until the
// divider's done is seen, and ST_DONE, which updates the tracked values
// and raises out_ch.valid.
// The divider retires one quotient bit per cycle and sets the pace:
// in_ch.ready is high only between requests, so a new request is taken only
// after the previous one has committed its result in ST_DONE.
// A finished result waits in the output register; a new request is still
// accepted and worked on, and is held back only in ST_DONE until
// the previous result has been taken.
// Reset (synchronous, rst_n low) restores the register defaults, marks both
// modes fresh and clears the displayed and carried percentages.
module battery_charge_percent_tracker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  bcpt_in_if.sink                          in_ch,
  bcpt_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [bcpt_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [bcpt_pkg::CfgW-1:0]        cfg_data
);

  // configuration registers
  logic [bcpt_pkg::CntW-1:0]   count_r;
  logic                        kind_r;
  logic [bcpt_pkg::CfgW-1:0]   tubular_r;
  logic [bcpt_pkg::CfgW-1:0]   flat_r;
  logic [bcpt_pkg::CfgW-1:0]   empty_r;
  logic [bcpt_pkg::CfgW-1:0]   nominal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= bcpt_pkg::CntW'(1);
      kind_r    <= 1'b0;
      tubular_r <= '0;
      flat_r    <= '0;
      empty_r   <= '0;
      nominal_r <= '0;
    end else if (cfg_we) begin
      case (bcpt_pkg::cfg_idx_t'(cfg_index))
        bcpt_pkg::CFG_COUNT:   count_r   <= cfg_data[bcpt_pkg::CntW-1:0];
        bcpt_pkg::CFG_KIND:    kind_r    <= cfg_data[0];
        bcpt_pkg::CFG_TUBULAR: tubular_r <= cfg_data;
        bcpt_pkg::CFG_FLAT:    flat_r    <= cfg_data;
        bcpt_pkg::CFG_EMPTY:   empty_r   <= cfg_data;
        bcpt_pkg::CFG_NOMINAL: nominal_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  bcpt_pkg::state_t     state_r, state_nxt;
  bcpt_pkg::div_ctrl_t  div_ctrl;
  bcpt_pkg::div_stat_t  div_stat;
  bcpt_pkg::trk_req_t   trk_req;
  logic                 in_take;
  logic                 out_free;
  logic                 commit;
  logic                 out_valid_r, out_valid_nxt;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcpt_pkg::ST_IDLE:  if (in_ch.valid) state_nxt = bcpt_pkg::ST_PREP;
      bcpt_pkg::ST_PREP:  state_nxt = bcpt_pkg::ST_SCALE;
      bcpt_pkg::ST_SCALE: state_nxt = bcpt_pkg::ST_DIV;
      bcpt_pkg::ST_DIV:   if (div_stat.done) state_nxt = bcpt_pkg::ST_DONE;
      bcpt_pkg::ST_DONE:  if (out_free) state_nxt = bcpt_pkg::ST_IDLE;
      default:            state_nxt = bcpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready    = 1'b0;
    div_ctrl.start = 1'b0;
    commit         = 1'b0;
    case (state_r)
      bcpt_pkg::ST_IDLE:  in_ch.ready = 1'b1;
      bcpt_pkg::ST_SCALE: div_ctrl.start = 1'b1;
      bcpt_pkg::ST_DONE:  commit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcpt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture
  logic [bcpt_pkg::CvW-1:0]    cv_r;
  logic [bcpt_pkg::LoadW-1:0]  load_r;
  logic                        backup_r;
  logic                        charged_r;
  logic                        restart_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      cv_r      <= in_ch.pack_centivolts;
      load_r    <= in_ch.load_pct;
      backup_r  <= in_ch.on_backup;
      charged_r <= in_ch.fully_charged;
      restart_r <= in_ch.restart_tracking;
    end
  end

  // floor, divisor and pack voltage in mV
  logic [bcpt_pkg::VoltW-1:0]   cv_ext;
  logic [bcpt_pkg::VoltW-1:0]   volt_mv;
  logic [bcpt_pkg::CfgW-1:0]    floor_sel;
  logic [bcpt_pkg::FloorW-1:0]  floor_mv;
  logic [bcpt_pkg::SpanW-1:0]   span_base;
  logic [bcpt_pkg::SpanW-1:0]   span_mv;
  logic [bcpt_pkg::SpanW-1:0]   load_drop;
  logic [bcpt_pkg::SpanW-1:0]   dsor_mv;

  assign cv_ext    = {{(bcpt_pkg::VoltW-bcpt_pkg::CvW){cv_r[bcpt_pkg::CvW-1]}}, cv_r};
  assign volt_mv   = (cv_ext << 3) + (cv_ext << 1);
  assign floor_sel = backup_r ? empty_r : (kind_r ? tubular_r : flat_r);
  assign floor_mv  = {{(bcpt_pkg::FloorW-bcpt_pkg::CntW){1'b0}}, count_r} *
                     {{(bcpt_pkg::FloorW-bcpt_pkg::CfgW){1'b0}}, floor_sel};
  assign span_base = bcpt_pkg::FullScaleMv -
                     {{(bcpt_pkg::SpanW-bcpt_pkg::CfgW){1'b0}}, nominal_r};
  assign span_mv   = {{(bcpt_pkg::SpanW-bcpt_pkg::CntW){1'b0}}, count_r} * span_base;
  // 7 mV per load percent, only on backup
  assign load_drop = ({{(bcpt_pkg::SpanW-bcpt_pkg::LoadW){1'b0}}, load_r} << 3) -
                     {{(bcpt_pkg::SpanW-bcpt_pkg::LoadW){1'b0}}, load_r};
  assign dsor_mv   = span_mv - (backup_r ? load_drop : '0);

  logic [bcpt_pkg::VoltW-1:0]   volt_r;
  logic [bcpt_pkg::FloorW-1:0]  floor_r;
  logic [bcpt_pkg::SpanW-1:0]   dsor_r;

  always_ff @(posedge clk) begin
    if (state_r == bcpt_pkg::ST_PREP) begin
      volt_r  <= volt_mv;
      floor_r <= floor_mv;
      dsor_r  <= dsor_mv;
    end
  end

  // excess over the floor, scaled by 100
  logic [bcpt_pkg::VoltW:0]    vdiff;
  logic [bcpt_pkg::DiffW-1:0]  excess;
  logic [bcpt_pkg::NumW-1:0]   excess_ext;
  logic [bcpt_pkg::NumW-1:0]   num;
  logic                        dsor_pos;
  logic                        dsor_ok_r;
  logic [bcpt_pkg::NumW-1:0]   quotient;
  logic [bcpt_pkg::NumW-1:0]   pct_raw;

  assign vdiff      = {volt_r[bcpt_pkg::VoltW-1], volt_r} -
                      {{(bcpt_pkg::VoltW+1-bcpt_pkg::FloorW){1'b0}}, floor_r};
  assign excess     = vdiff[bcpt_pkg::VoltW] ? '0 : vdiff[bcpt_pkg::DiffW-1:0];
  assign excess_ext = {{(bcpt_pkg::NumW-bcpt_pkg::DiffW){1'b0}}, excess};
  assign num        = (excess_ext << 6) + (excess_ext << 5) + (excess_ext << 2);
  assign dsor_pos   = !dsor_r[bcpt_pkg::SpanW-1] && (dsor_r != '0);

  always_ff @(posedge clk) begin
    if (state_r == bcpt_pkg::ST_SCALE) dsor_ok_r <= dsor_pos;
  end

  bcpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (num),
    .divisor  (dsor_r[bcpt_pkg::DsorW-1:0]),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign pct_raw = dsor_ok_r ? quotient : '0;

  assign trk_req.commit        = commit;
  assign trk_req.on_backup     = backup_r;
  assign trk_req.fully_charged = charged_r;
  assign trk_req.restart       = restart_r;

  bcpt_track u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (trk_req),
    .pct_raw         (pct_raw),
    .charge_shown    (out_ch.charge_pct_shown),
    .discharge_shown (out_ch.discharge_pct_shown)
  );

  assign out_ch.valid = out_valid_r;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ch.ready)
    else $error("request taken while a reading is in progress");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> out_free)
    else $error("result overwrote one not yet taken");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == bcpt_pkg::ST_DIV)
    else $error("divider running outside its state");

endmodule
